FILE: rtl/pla_pkg.sv
// Shared types and constants for the pair label assigner.
// Holds the controller state encoding and the command and status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pla_pkg;

	// Field widths fixed by the stream format.
	localparam int IN_LABEL_W  = 7;
	localparam int OUT_LABEL_W = 13;
	localparam int STORED_W    = 12;
	localparam int LABEL_LIMIT = 4096;

	// Result value that means no label.
	localparam logic [OUT_LABEL_W-1:0] NO_LABEL = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_TAB,
		ST_RD_REV,
		ST_DECIDE,
		ST_FINISH
	} pla_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic rd_tab;
		logic rd_rev;
		logic decide;
		logic load_out;
	} pla_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic in_direct;
		logic out_free;
	} pla_sts_t;

endpackage

`default_nettype wire

FILE: rtl/pla_ctrl.sv
// Controller state machine for the pair label assigner.
// Sequences table lookup, check and update; depends on pla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pla_ctrl
	import pla_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       s_tvalid,
	output logic      s_tready,
	input  pla_sts_t  sts,
	output pla_cmd_t  cmd
);

	pla_state_t state_q;
	pla_state_t state_d;

	// State register; after reset the table is zeroed before any input.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = sts.in_direct ? ST_FINISH : ST_RD_TAB;
				end
			end
			ST_RD_TAB: state_d = ST_RD_REV;
			ST_RD_REV: state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_RD_TAB: cmd.rd_tab = 1'b1;
			ST_RD_REV: cmd.rd_rev = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			ST_FINISH: cmd.load_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

	// A direct item skips the table and goes straight to the result stage.
	a_direct_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.capture && sts.in_direct) |=> (state_q == ST_FINISH))
		else $error("direct transaction did not skip table access");

	// A table read is always followed by the reverse read.
	a_tab_then_rev: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_tab |=> cmd.rd_rev)
		else $error("reverse read did not follow table read");

	// The table update is followed by the result stage.
	a_decide_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |=> (state_q == ST_FINISH))
		else $error("decide not followed by finish");

endmodule

`default_nettype wire

FILE: rtl/pla_datapath.sv
// Datapath for the pair label assigner: pair table, reverse table,
// label counter and output register; depends on pla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pla_datapath
	import pla_pkg::*;
#(
	parameter int MAX_MAXIMA = 64,
	parameter int MAX_MINIMA = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire  [15:0] s_tdata,
	input  wire         s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,
	input  pla_cmd_t    cmd,
	output pla_sts_t    sts
);

	localparam int TAB_DEPTH = MAX_MAXIMA * MAX_MINIMA;
	localparam int IDX_W     = $clog2(TAB_DEPTH);
	localparam int LIM_IDX_W = $clog2(LABEL_LIMIT);

	// An entry is valid when its stored label lies below the counter and the
	// reverse table points back at it, so a clear only needs to zero the counter.
	// After reset a clearing pass zeroes the pair table once, so every entry
	// holds a defined label before the first lookup.
	logic [STORED_W-1:0]  tab_mem [TAB_DEPTH];
	logic [IDX_W-1:0]     rev_mem [LABEL_LIMIT];

	logic [IN_LABEL_W-1:0] asc_raw;
	logic [IN_LABEL_W-1:0] desc_raw;
	logic                  asc_ok;
	logic                  desc_ok;
	logic [IDX_W-1:0]      idx_in;
	logic                  hit;
	logic                  full;

	logic [IDX_W-1:0]       clr_idx_q;
	logic [IDX_W-1:0]       idx_q;
	logic [STORED_W-1:0]    tab_rd_q;
	logic [IDX_W-1:0]       rev_rd_q;
	logic                   lt_q;
	logic [OUT_LABEL_W-1:0] next_label_q;
	logic [OUT_LABEL_W-1:0] res_label_q;
	logic                   res_new_q;
	logic                   m_tvalid_q;
	logic [OUT_LABEL_W-1:0] m_label_q;
	logic                   m_new_q;

	// Decode the incoming labels; negative or out-of-range labels are unassigned.
	always_comb begin
		asc_raw  = s_tdata[IN_LABEL_W-1:0];
		desc_raw = s_tdata[2*IN_LABEL_W-1:IN_LABEL_W];
		asc_ok   = !asc_raw[IN_LABEL_W-1] && (int'(asc_raw[IN_LABEL_W-2:0]) < MAX_MAXIMA);
		desc_ok  = !desc_raw[IN_LABEL_W-1] && (int'(desc_raw[IN_LABEL_W-2:0]) < MAX_MINIMA);
		idx_in   = IDX_W'(desc_raw[IN_LABEL_W-2:0]) * IDX_W'(MAX_MAXIMA)
			+ IDX_W'(asc_raw[IN_LABEL_W-2:0]);
		sts.in_direct = s_tuser || !asc_ok || !desc_ok;
		sts.out_free  = !m_tvalid_q || m_tready;
		sts.clr_done  = (clr_idx_q == IDX_W'(TAB_DEPTH - 1));
	end

	assign hit  = lt_q && (rev_rd_q == idx_q);
	assign full = (next_label_q == OUT_LABEL_W'(LABEL_LIMIT));

	// Address counter of the clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// Table reads and writes.
	always_ff @(posedge clk) begin
		if (cmd.rd_tab) begin
			tab_rd_q <= tab_mem[idx_q];
		end
		if (cmd.rd_rev) begin
			rev_rd_q <= rev_mem[tab_rd_q[LIM_IDX_W-1:0]];
		end
		if (cmd.clr_wr) begin
			tab_mem[clr_idx_q] <= '0;
		end else if (cmd.decide && !hit && !full) begin
			tab_mem[idx_q] <= next_label_q[STORED_W-1:0];
		end
		if (cmd.decide && !hit && !full) begin
			rev_mem[next_label_q[LIM_IDX_W-1:0]] <= idx_q;
		end
	end

	// Captured index and the counter compare taken with the reverse read.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= idx_in;
		end
		if (cmd.rd_rev) begin
			lt_q <= ({1'b0, tab_rd_q} < next_label_q);
		end
	end

	// Label counter and pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_label_q <= '0;
			res_label_q  <= NO_LABEL;
			res_new_q    <= 1'b0;
		end else begin
			if (cmd.capture) begin
				res_label_q <= NO_LABEL;
				res_new_q   <= 1'b0;
				if (s_tuser) begin
					next_label_q <= '0;
				end
			end
			if (cmd.decide) begin
				if (hit) begin
					res_label_q <= {1'b0, tab_rd_q};
					res_new_q   <= 1'b0;
				end else if (full) begin
					res_label_q <= NO_LABEL;
					res_new_q   <= 1'b0;
				end else begin
					res_label_q  <= next_label_q;
					res_new_q    <= 1'b1;
					next_label_q <= next_label_q + 1'b1;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_label_q  <= '0;
			m_new_q    <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
				m_label_q  <= res_label_q;
				m_new_q    <= res_new_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_new_q, m_label_q};

	// The counter never passes the label limit.
	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_label_q <= OUT_LABEL_W'(LABEL_LIMIT))
		else $error("label counter past limit");

	// A fresh label advances the counter by one.
	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && !hit && !full) |=> (next_label_q == $past(next_label_q) + 1'b1))
		else $error("counter did not advance on new label");

	// A fresh label is never the no-label value.
	a_new_has_label: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_new_q) |-> !m_label_q[OUT_LABEL_W-1])
		else $error("new pair reported without a label");

endmodule

`default_nettype wire

FILE: rtl/pair_label_assigner.sv
// Pair label assigner.
// Input stream: s_tdata holds the ascending label in bits 6:0 and the
// descending label in bits 13:7 (both signed, negative means unassigned);
// s_tuser is the action, 1 clears the table and the label counter.
// Output stream: m_tdata holds the signed 13-bit region label in bits 12:0
// and the is_new flag in bit 13; each input transaction gives one result.
// The block works on one item at a time: a labeling transaction passes the
// table read, the reverse-table check and the update in that order before
// its result is loaded into the output register, while a clear or an
// unassigned pair goes straight to the result stage. No new transaction is
// accepted until the current one has reached the output register.
// After reset the block holds s_tready low while it zeroes all MAX_MAXIMA *
// MAX_MINIMA entries of the pair table (4096 with the defaults) and drops any
// pending result. A clear action empties the table at once: only the counter
// is zeroed, and entries are validated against a reverse table.
// When the receiver stalls, the result waits in the output register and the
// block accepts one further item and works it up to its result stage.
`timescale 1ns / 1ps
`default_nettype none

module pair_label_assigner
	import pla_pkg::*;
#(
	parameter int MAX_MAXIMA = 64,
	parameter int MAX_MINIMA = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [6:0] ascending_label, [13:7] descending_label
	input  wire         s_tuser,   // [0] action
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata    // [12:0] region_label, [13] is_new
);

	pla_cmd_t cmd;
	pla_sts_t sts;

	pla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pla_datapath #(
		.MAX_MAXIMA (MAX_MAXIMA),
		.MAX_MINIMA (MAX_MINIMA)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

`default_nettype wire
